// ===== hw/rtl/bpc_pkg.sv =====
// Shared types, constants and pixel-combine functions for the bitplane to
// chunky pixel converter. No dependencies; every other file imports it.

package bpc_pkg;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_MED  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;

  localparam int PLANES      = 4;
  localparam int PLANE_W     = 16;
  localparam int PIXEL_W     = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [1:0] LAST_IDX_PLANES = 2'd3;
  localparam logic [1:0] LAST_IDX_LINES  = 2'd1;

  typedef logic [PLANE_W-1:0] plane_word_t;
  typedef logic [PIXEL_W-1:0] pixel_word_t;

  typedef struct packed {
    plane_word_t [PLANES-1:0] planes;
    logic                     two_line;
  } group_t;

  function automatic pixel_word_t combine_planes(plane_word_t [PLANES-1:0] pl,
                                                 logic [1:0] k);
    pixel_word_t word;
    logic [3:0]  pix;
    word = '0;
    for (int j = 0; j < 4; j++) begin
      pix = {k, 2'(j)};
      word[8*j +: 8] = {4'b0000, pl[3][pix], pl[2][pix], pl[1][pix], pl[0][pix]};
    end
    return word;
  endfunction

  function automatic pixel_word_t combine_lines(plane_word_t upper, plane_word_t lower,
                                                logic r);
    pixel_word_t word;
    logic [3:0]  b0;
    logic [3:0]  b1;
    word = '0;
    for (int j = 0; j < 4; j++) begin
      b0 = {r, 2'(j), 1'b0};
      b1 = {r, 2'(j), 1'b1};
      word[8*j +: 8] = {4'b0000, lower[b1], lower[b0], upper[b1], upper[b0]};
    end
    return word;
  endfunction

endpackage

// ===== hw/rtl/bpc_front.sv =====
// Front end: holds the display mode register, accepts input transactions and
// tags each group with its combine kind. Depends on bpc_pkg.

module bpc_front import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  plane_word_t in_plane_word0,
  input  plane_word_t in_plane_word1,
  input  plane_word_t in_plane_word2,
  input  plane_word_t in_plane_word3,
  input  logic        q_full,
  output logic        q_push,
  output group_t      q_entry
);

  logic [1:0] display_mode_r;
  logic [1:0] display_mode_nxt;

  always_comb begin
    display_mode_nxt = display_mode_r;
    if (cfg_write_en) begin
      display_mode_nxt = cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= MODE_LOW;
    end else begin
      display_mode_r <= display_mode_nxt;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.planes[0] = in_plane_word0;
    q_entry.planes[1] = in_plane_word1;
    q_entry.planes[2] = in_plane_word2;
    q_entry.planes[3] = in_plane_word3;
    // Any mode at or above high res uses the two-line combine.
    q_entry.two_line  = (display_mode_r >= MODE_HIGH);
  end

endmodule

// ===== hw/rtl/bpc_queue.sv =====
// Short queue of classified groups between the front and back ends.
// Depends on bpc_pkg.

module bpc_queue import bpc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   valid,
  output group_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/bpc_back.sv =====
// Back end: steps through the words of the current group, one per cycle
// unless out_ready stalls it, into an output register. Depends on bpc_pkg.

module bpc_back import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  group_t      q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output pixel_word_t out_pixel_word,
  output logic        out_last_word
);

  group_t      cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  pixel_word_t pixel_r, pixel_nxt;
  logic        last_r, last_nxt;
  logic        advance;
  logic        is_last;
  pixel_word_t word;

  assign advance = !out_valid_r || out_ready;
  assign is_last = cur_r.two_line ? (idx_r == LAST_IDX_LINES) : (idx_r == LAST_IDX_PLANES);
  assign word    = cur_r.two_line ? combine_lines(cur_r.planes[0], cur_r.planes[1], idx_r[0])
                                  : combine_planes(cur_r.planes, idx_r);
  assign q_pop   = q_valid && (!cur_valid_r || (advance && is_last));

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    pixel_nxt     = pixel_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = cur_valid_r;
      if (cur_valid_r) begin
        pixel_nxt = word;
        last_nxt  = is_last;
        if (is_last) begin
          cur_valid_nxt = 1'b0;
          idx_nxt       = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
    if (q_pop) begin
      cur_nxt       = q_head;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    pixel_r <= pixel_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = pixel_r;
  assign out_last_word  = last_r;

endmodule

// ===== hw/rtl/bitplane_to_chunky_pixels_unit.sv =====
// Top level of the bitplane to chunky pixel converter.
// Depends on bpc_pkg, bpc_front, bpc_queue and bpc_back.

// Each input transaction carries one 16-pixel group of four plane words and
// yields four 32-bit pixel words in low and medium res, or two in high res
// and the unused mode value, with the final word of each group marked by
// out_last_word. The back end emits one pixel word per cycle into its output
// register unless out_ready stalls it; input transactions are taken into a
// queue of QUEUE_DEPTH groups while earlier groups drain, and a group then
// passes through the current-group register to the output register.
// The display mode is sampled per group when it is accepted.

module bitplane_to_chunky_pixels_unit import bpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  plane_word_t in_plane_word0,
  input  plane_word_t in_plane_word1,
  input  plane_word_t in_plane_word2,
  input  plane_word_t in_plane_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output pixel_word_t out_pixel_word,
  output logic        out_last_word
);

  logic   q_full, q_push, q_valid, q_pop;
  group_t q_entry, q_head;

  bpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_plane_word0 (in_plane_word0),
    .in_plane_word1 (in_plane_word1),
    .in_plane_word2 (in_plane_word2),
    .in_plane_word3 (in_plane_word3),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  bpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head)
  );

  bpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_word (out_pixel_word),
    .out_last_word  (out_last_word)
  );

endmodule

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checker for the bitplane to chunky pixel converter, bound to the
// top level. Depends on bpc_pkg.

module bpc_checker import bpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_write_en,
  input logic [1:0]  cfg_write_data,
  input logic        in_valid,
  input logic        in_ready,
  input plane_word_t in_plane_word0,
  input plane_word_t in_plane_word1,
  input plane_word_t in_plane_word2,
  input plane_word_t in_plane_word3,
  input logic        out_valid,
  input logic        out_ready,
  input pixel_word_t out_pixel_word,
  input logic        out_last_word
);

  logic [1:0] mode_r;
  logic [1:0] word_cnt_r;
  logic       high_mode;
  logic [1:0] last_idx;

  assign high_mode = (mode_r >= MODE_HIGH);
  assign last_idx  = high_mode ? LAST_IDX_LINES : LAST_IDX_PLANES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_LOW;
      word_cnt_r <= '0;
    end else begin
      if (cfg_write_en) begin
        mode_r <= cfg_write_data;
      end
      if (out_valid && out_ready) begin
        word_cnt_r <= out_last_word ? 2'd0 : word_cnt_r + 2'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_word) && $stable(out_last_word))
    else $error("Output transaction changed while stalled.");

  a_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pixel_word & 32'hF0F0_F0F0) == 32'h0))
    else $error("Upper nibble of a pixel byte is not zero.");

  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (word_cnt_r == last_idx)))
    else $error("Last word marker does not match the group's word count.");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=> out_valid)
    else $error("Gap inside a group's run of words.");

endmodule

bind bitplane_to_chunky_pixels_unit bpc_checker u_bpc_checker (.*);

// ===== tb/sv/tb_bitplane_to_chunky_pixels_unit.sv =====
// Self-checking testbench for bitplane_to_chunky_pixels_unit: directed and random groups
// in all display modes, with random idling, checked against an internal pixel predictor.
// Depends on bpc_pkg and the RTL of the converter; reads no files.
`timescale 1ns / 100ps

module tb_bitplane_to_chunky_pixels_unit;
  import bpc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 22;
  localparam int DIR_ROWS_N = 21;

  typedef struct packed {
    logic [1:0]  mode;
    plane_word_t w0;
    plane_word_t w1;
    plane_word_t w2;
    plane_word_t w3;
    logic        has_exp;
    pixel_word_t exp_word;
  } dir_row_t;

  typedef struct packed {
    pixel_word_t pixels;
    logic        last;
  } pixel_result_t;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{MODE_LOW,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h00000000},
    '{MODE_LOW,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0F0F0F0F},
    '{MODE_LOW,    16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h01010101},
    '{MODE_LOW,    16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 32'h02020202},
    '{MODE_LOW,    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 32'h04040404},
    '{MODE_LOW,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 32'h08080808},
    '{MODE_LOW,    16'h0001, 16'h8000, 16'h1234, 16'hABCD, 1'b0, 32'h0},
    '{MODE_LOW,    16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 1'b0, 32'h0},
    '{MODE_MED,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0F0F0F0F},
    '{MODE_MED,    16'h8001, 16'h4002, 16'h2004, 16'h1008, 1'b0, 32'h0},
    '{MODE_MED,    16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 1'b0, 32'h0},
    '{MODE_HIGH,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h00000000},
    '{MODE_HIGH,   16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h03030303},
    '{MODE_HIGH,   16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 32'h0C0C0C0C},
    '{MODE_HIGH,   16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 32'h0F0F0F0F},
    '{MODE_HIGH,   16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 32'h00000000},
    '{MODE_HIGH,   16'h5555, 16'hAAAA, 16'h1234, 16'h5678, 1'b0, 32'h0},
    '{MODE_HIGH,   16'h8001, 16'h0180, 16'hFFFF, 16'h0000, 1'b0, 32'h0},
    '{MODE_UNUSED, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 32'h03030303},
    '{MODE_UNUSED, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{MODE_LOW,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0F0F0F0F}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [1:0]  cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  plane_word_t in_plane_word0;
  plane_word_t in_plane_word1;
  plane_word_t in_plane_word2;
  plane_word_t in_plane_word3;
  logic        out_valid;
  logic        out_ready;
  pixel_word_t out_pixel_word;
  logic        out_last_word;

  pixel_result_t pending_pixels [$];
  logic [1:0]    cur_mode;
  logic          idle_on;
  logic          long_hold_req;
  logic          long_hold_done;
  int            error_count;
  int            groups_sent;
  int            words_checked;
  int            cycle_count = 0;

  bitplane_to_chunky_pixels_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_plane_word0 (in_plane_word0),
    .in_plane_word1 (in_plane_word1),
    .in_plane_word2 (in_plane_word2),
    .in_plane_word3 (in_plane_word3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_word (out_pixel_word),
    .out_last_word  (out_last_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void predict_group(logic [1:0] mode, plane_word_t w0, plane_word_t w1,
                                        plane_word_t w2, plane_word_t w3);
    plane_word_t   pl [4];
    pixel_result_t res;
    int            count;
    int            b;
    logic [3:0]    nib;
    pl = '{w0, w1, w2, w3};
    count = mode[1] ? 2 : 4;
    for (int k = 0; k < count; k++) begin
      res.pixels = '0;
      for (int j = 0; j < 4; j++) begin
        if (mode[1]) begin
          b = 8 * k + 2 * j;
          nib = {w1[b+1], w1[b], w0[b+1], w0[b]};
        end else begin
          b = 4 * k + j;
          nib = {pl[3][b], pl[2][b], pl[1][b], pl[0][b]};
        end
        res.pixels[8*j +: 8] = {4'b0000, nib};
      end
      res.last = (k == count - 1);
      pending_pixels.push_back(res);
    end
  endfunction

  function automatic void push_known_group(logic [1:0] mode, pixel_word_t word);
    pixel_result_t res;
    int            count;
    count = mode[1] ? 2 : 4;
    for (int k = 0; k < count; k++) begin
      res.pixels = word;
      res.last = (k == count - 1);
      pending_pixels.push_back(res);
    end
  endfunction

  function automatic plane_word_t rand_plane();
    plane_word_t w;
    case ($urandom_range(0, 5))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w = 16'h0001 << $urandom_range(0, 15);
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic send_group(input plane_word_t w0, input plane_word_t w1,
                            input plane_word_t w2, input plane_word_t w3,
                            input logic has_exp, input pixel_word_t exp_word);
    logic fire;
    in_valid <= 1'b1;
    in_plane_word0 <= w0;
    in_plane_word1 <= w1;
    in_plane_word2 <= w2;
    in_plane_word3 <= w3;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = in_ready;
      if (fire) begin
        if (has_exp) begin
          push_known_group(cur_mode, exp_word);
        end else begin
          predict_group(cur_mode, w0, w1, w2, w3);
        end
        groups_sent++;
      end
      @(posedge clk);
    end
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= mode;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_mode = mode;
  endtask

  initial begin
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word %h (last %b)", $time, out_pixel_word,
                 out_last_word);
        error_count++;
      end else begin
        if (out_pixel_word !== pending_pixels[0].pixels) begin
          $display("%0t: pixel word mismatch, expected %h, got %h", $time,
                   pending_pixels[0].pixels, out_pixel_word);
          error_count++;
        end
        if (out_last_word !== pending_pixels[0].last) begin
          $display("%0t: last word flag mismatch, expected %b, got %b", $time,
                   pending_pixels[0].last, out_last_word);
          error_count++;
        end
        void'(pending_pixels.pop_front());
        words_checked++;
      end
    end
  end

  initial begin
    logic [1:0] phase_mode;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = MODE_LOW;
    in_valid = 1'b0;
    in_plane_word0 = '0;
    in_plane_word1 = '0;
    in_plane_word2 = '0;
    in_plane_word3 = '0;
    cur_mode = MODE_LOW;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    error_count = 0;
    groups_sent = 0;
    words_checked = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      if (DIR_ROWS[i].mode != cur_mode) set_mode(DIR_ROWS[i].mode);
      send_group(DIR_ROWS[i].w0, DIR_ROWS[i].w1, DIR_ROWS[i].w2, DIR_ROWS[i].w3,
                 DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_word);
      sender_gap();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_mode = MODE_MED;
        1: phase_mode = MODE_HIGH;
        2: phase_mode = MODE_LOW;
        3: phase_mode = MODE_UNUSED;
        4: phase_mode = 2'($urandom_range(0, 3));
        default: phase_mode = MODE_LOW;
      endcase
      set_mode(phase_mode);
      if (ph == PHASES - 1) idle_on = 1'b0;
      if (ph == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_group(rand_plane(), rand_plane(), rand_plane(), rand_plane(), 1'b0, '0);
        if (ph == 0 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end else if (ph != 2) begin
          sender_gap();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d pixel words never arrived", $time, pending_pixels.size());
      error_count++;
    end
    $display("Converted %0d groups across low, medium, high and the unused mode value,",
             groups_sent);
    $display("checking %0d pixel words under random and long output stalls.", words_checked);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
